/* rtl/core/ffaa_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// ffaa_pkg
// Types and codes shared by the allocator files.
// -----------------------------------------------------------------------------
package ffaa_pkg;
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD     = 3'd1;
    localparam logic [2:0] ST_NOFIT   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] address;
        logic [31:0] request_size;
        logic [31:0] alignment;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] pointer;
    } rsp_t;
endpackage
`default_nettype wire

/* rtl/core/ffaa_if.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// ffaa_req_if / ffaa_rsp_if
// Valid/ready channels for request and response words.
// -----------------------------------------------------------------------------
interface ffaa_req_if import ffaa_pkg::*;;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ffaa_rsp_if import ffaa_pkg::*;;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/first_fit_aligned_allocator_top.sv */
`default_nettype none
// Steps: add moves every free entry up by one and writes the new extent at entry 0;
// allocate scans free entries, then live slots, then moves entries; free looks up the
// live slot, then scans for the position, shifts entries and runs the merge pass.
// Throughput: one word in process at a time; the next word is taken while the result
// waits in the output register.
// Reset: free count, live valid bits and control clear at once; memories need none.
// -----------------------------------------------------------------------------
// first_fit_aligned_allocator_top
// First-fit free-extent allocator with alignment, splitting and coalescing.
// -----------------------------------------------------------------------------
module first_fit_aligned_allocator_top
    import ffaa_pkg::*;
#(
    parameter int FREE_SLOTS   = 16,
    parameter int LIVE_SLOTS   = 16,
    parameter int HEADER_BYTES = 24,
    parameter int WORD_BYTES   = 8
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ffaa_req_if.sink   req,
    ffaa_rsp_if.source rsp
);
    localparam int FW = $clog2(FREE_SLOTS);
    localparam int LW = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;
    localparam int CW = $clog2(FREE_SLOTS + 1);
    localparam logic [32:0] HDR  = 33'(HEADER_BYTES);
    localparam logic [32:0] WM   = 33'(WORD_BYTES - 1);
    localparam logic [32:0] MINB = 33'(HEADER_BYTES + WORD_BYTES);

    localparam logic [4:0] S_IDLE  = 5'd0,  S_ADD   = 5'd1,  S_AL_RD = 5'd2,
                           S_AL_CK = 5'd3,  S_AL_LV = 5'd4,  S_AL_DO = 5'd5,
                           S_SH_RD = 5'd6,  S_SH_WR = 5'd7,  S_WR1   = 5'd8,
                           S_WR2   = 5'd9,  S_RM_RD = 5'd10, S_RM_WR = 5'd11,
                           S_FR_LV = 5'd12, S_FR_LC = 5'd13, S_FR_RD = 5'd14,
                           S_FR_CK = 5'd15, S_MG_0  = 5'd16, S_MG_P  = 5'd17,
                           S_MG_RD = 5'd18, S_MG_CK = 5'd19, S_MG_END = 5'd20,
                           S_DONE  = 5'd21;

    // free table: one memory, {start,length}, one access per cycle
    logic [63:0] fmem [FREE_SLOTS];
    logic [63:0] frd;
    logic          fwe;
    logic [FW-1:0] faddr;
    logic [63:0]   fwd;
    always_ff @(posedge clk)
    begin
        if (fwe) fmem[faddr] <= fwd;
        frd <= fmem[faddr];
    end

    // live table memory: {pointer,length}
    logic [63:0] lmem [LIVE_SLOTS];
    logic [63:0] lrd;
    logic          lwe;
    logic [LW-1:0] laddr;
    logic [63:0]   lwd;
    always_ff @(posedge clk)
    begin
        if (lwe) lmem[laddr] <= lwd;
        lrd <= lmem[laddr];
    end

    logic [LIVE_SLOTS-1:0] lvalid_reg, lvalid_next;
    logic [CW-1:0] count_reg, count_next;
    logic [4:0]    state_reg, state_next, ret_reg, ret_next;
    req_t          q_reg, q_next;
    logic [CW-1:0] i_reg, i_next, k_reg, k_next, pos_reg, pos_next;
    logic [CW-1:0] wpos_reg, wpos_next;                // first entry to write
    logic [LW:0]   j_reg, j_next;
    logic [31:0]   a_reg, a_next, b_reg, b_next;       // pending entry
    logic [31:0]   c_reg, c_next, d_reg, d_next;       // second pending entry
    logic          c_v_reg, c_v_next;
    logic [32:0]   size_reg, size_next;
    logic [31:0]   slack_reg, slack_next;
    logic [31:0]   ps_reg, ps_next, pl_reg, pl_next;   // found or merge prev entry
    logic [LW-1:0] slot_reg, slot_next;
    logic          ov_reg, ov_next;
    rsp_t          res_reg, res_next;                  // result being built
    rsp_t          out_reg, out_next;                  // result on offer

    // accept a new word while the previous result waits downstream
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = ov_reg;
    assign rsp.data  = out_reg;

    logic [32:0] blk, endp, al, slk, need, rem;
    logic [31:0] am1;
    always_comb
    begin
        am1  = q_reg.alignment - 32'd1;
        blk  = ({1'b0, q_reg.address} + WM) & ~WM;
        endp = {1'b0, q_reg.address} + {1'b0, q_reg.request_size};
        al   = {1'b0, q_reg.alignment};
        slk  = {1'b0, (32'd0 - frd[63:32]) & am1};
        // slack below a header: add the smallest multiple of alignment
        if (slk != 33'd0 && slk < HDR)
        begin
            if (al >= HDR) slk = slk + al;
            else slk = slk + ((HDR - slk + al - 33'd1) & ~(al - 33'd1));
        end
        need = size_reg + slk;
        rem  = {1'b0, pl_reg} - {1'b0, slack_reg} - size_reg;
    end

    always_comb
    begin
        state_next = state_reg; ret_next = ret_reg; q_next = q_reg;
        i_next = i_reg; k_next = k_reg; pos_next = pos_reg; j_next = j_reg;
        wpos_next = wpos_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        c_v_next = c_v_reg; size_next = size_reg; slack_next = slack_reg;
        ps_next = ps_reg; pl_next = pl_reg; slot_next = slot_reg;
        lvalid_next = lvalid_reg; count_next = count_reg;
        ov_next = ov_reg; out_next = out_reg; res_next = res_reg;
        fwe = 1'b0; faddr = i_reg[FW-1:0]; fwd = {a_reg, b_reg};
        lwe = 1'b0; laddr = j_reg[LW-1:0]; lwd = '0;
        if (ov_reg && rsp.ready) ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    q_next = req.data;
                    res_next = '{status: ST_BAD, pointer: 32'd0};
                    i_next = '0; j_next = '0;
                    case (req.data.opcode)
                        OP_ADD:   state_next = S_ADD;
                        OP_ALLOC: state_next = S_AL_RD;
                        OP_FREE:  state_next = S_FR_LV;
                        default:  state_next = S_DONE;
                    endcase
                    size_next = ({1'b0, req.data.request_size} + WM) & ~WM;
                end
            end
            S_ADD:
            begin
                if (blk + HDR > endp || endp[32] && endp[31:0] != 32'd0)
                    state_next = S_DONE;
                else if (count_reg >= CW'(FREE_SLOTS))
                begin
                    res_next.status = ST_FULL; state_next = S_DONE;
                end
                else
                begin
                    res_next.status = ST_OK;
                    a_next = 32'(blk + HDR);
                    b_next = 32'(endp - blk - HDR);
                    pos_next = '0; wpos_next = '0; c_v_next = 1'b0;
                    k_next = count_reg; count_next = count_reg + CW'(1);
                    ret_next = S_DONE; state_next = S_SH_RD;
                end
            end
            // open a gap: move entries pos..k-1 up by one, top first
            S_SH_RD:
            begin
                if (k_reg == pos_reg) state_next = S_WR1;
                else
                begin
                    faddr = FW'(k_reg - CW'(1)); state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                fwe = 1'b1; fwd = frd; faddr = FW'(k_reg);
                k_next = k_reg - CW'(1); state_next = S_SH_RD;
            end
            S_WR1:
            begin
                fwe = 1'b1; faddr = FW'(wpos_reg); fwd = {a_reg, b_reg};
                state_next = c_v_reg ? S_WR2 : ret_reg;
            end
            S_WR2:
            begin
                fwe = 1'b1; faddr = FW'(wpos_reg + CW'(1)); fwd = {c_reg, d_reg};
                state_next = ret_reg;
            end
            S_AL_RD:
            begin
                if (q_reg.request_size == 32'd0 || q_reg.alignment == 32'd0 ||
                    (q_reg.alignment & am1) != 32'd0)
                    state_next = S_DONE;
                else if (i_reg >= count_reg)
                begin
                    res_next.status = ST_NOFIT; state_next = S_DONE;
                end
                else state_next = S_AL_CK;
            end
            S_AL_CK:
            begin
                if ({1'b0, frd[31:0]} >= need)
                begin
                    slack_next = slk[31:0]; ps_next = frd[63:32]; pl_next = frd[31:0];
                    j_next = '0; state_next = S_AL_LV;
                end
                else
                begin
                    i_next = i_reg + CW'(1); state_next = S_AL_RD;
                end
            end
            S_AL_LV:
            begin
                if (j_reg >= (LW+1)'(LIVE_SLOTS))
                begin
                    res_next.status = ST_FULL; state_next = S_DONE;
                end
                else if (!lvalid_reg[j_reg[LW-1:0]])
                begin
                    slot_next = j_reg[LW-1:0]; state_next = S_AL_DO;
                end
                else j_next = j_reg + (LW+1)'(1);
            end
            // replace entry i by the slack entry and/or the remainder entry, or remove it if neither is kept
            S_AL_DO:
            begin
                if (slack_reg != 32'd0 && rem >= MINB && count_reg >= CW'(FREE_SLOTS))
                begin
                    res_next.status = ST_FULL; state_next = S_DONE;
                end
                else
                begin
                    res_next.status  = ST_OK;
                    res_next.pointer = ps_reg + slack_reg;
                    lwe = 1'b1; laddr = slot_reg;
                    lwd = {ps_reg + slack_reg,
                           (rem >= MINB) ? size_reg[31:0] : pl_reg - slack_reg};
                    lvalid_next[slot_reg] = 1'b1;
                    ret_next = S_DONE; c_v_next = 1'b0; wpos_next = i_reg;
                    pos_next = i_reg + CW'(1); k_next = i_reg + CW'(1);
                    c_next = ps_reg + slack_reg + size_reg[31:0] + HDR[31:0];
                    d_next = 32'(rem - HDR);
                    if (slack_reg != 32'd0)
                    begin
                        a_next = ps_reg; b_next = slack_reg - HDR[31:0];
                        if (rem >= MINB)
                        begin
                            c_v_next = 1'b1; k_next = count_reg;
                            count_next = count_reg + CW'(1);
                        end
                        state_next = S_SH_RD;
                    end
                    else if (rem >= MINB)
                    begin
                        a_next = ps_reg + slack_reg + size_reg[31:0] + HDR[31:0];
                        b_next = 32'(rem - HDR);
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        k_next = i_reg; count_next = count_reg - CW'(1);
                        state_next = S_RM_RD;
                    end
                end
            end
            // close the gap at k: move entries above down by one
            S_RM_RD:
            begin
                if (k_reg >= count_reg) state_next = ret_reg;
                else
                begin
                    faddr = FW'(k_reg + CW'(1)); state_next = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                fwe = 1'b1; fwd = frd; faddr = FW'(k_reg);
                k_next = k_reg + CW'(1); state_next = S_RM_RD;
            end
            S_FR_LV:
            begin
                if (q_reg.address == 32'd0)
                begin
                    res_next.status = ST_OK; state_next = S_DONE;
                end
                else if (j_reg >= (LW+1)'(LIVE_SLOTS))
                begin
                    res_next.status = ST_UNKNOWN; state_next = S_DONE;
                end
                else state_next = S_FR_LC;
            end
            S_FR_LC:
            begin
                if (lvalid_reg[j_reg[LW-1:0]] && lrd[63:32] == q_reg.address)
                begin
                    if (count_reg >= CW'(FREE_SLOTS))
                    begin
                        res_next.status = ST_FULL; state_next = S_DONE;
                    end
                    else
                    begin
                        a_next = q_reg.address; b_next = lrd[31:0];
                        lvalid_next[j_reg[LW-1:0]] = 1'b0;
                        res_next.status = ST_OK; i_next = '0; state_next = S_FR_RD;
                    end
                end
                else
                begin
                    j_next = j_reg + (LW+1)'(1); state_next = S_FR_LV;
                end
            end
            S_FR_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    pos_next = i_reg; wpos_next = i_reg; k_next = count_reg;
                    count_next = count_reg + CW'(1); c_v_next = 1'b0;
                    ret_next = S_MG_0; state_next = S_SH_RD;
                end
                else state_next = S_FR_CK;
            end
            S_FR_CK:
            begin
                if (frd[63:32] > q_reg.address)
                begin
                    pos_next = i_reg; wpos_next = i_reg; k_next = count_reg;
                    count_next = count_reg + CW'(1); c_v_next = 1'b0;
                    ret_next = S_MG_0; state_next = S_SH_RD;
                end
                else
                begin
                    i_next = i_reg + CW'(1); state_next = S_FR_RD;
                end
            end
            // merge pass: compact in place, prev held in ps/pl, written back at wpos
            S_MG_0:
            begin
                if (count_reg < CW'(2)) state_next = S_DONE;
                else
                begin
                    faddr = '0; state_next = S_MG_P;
                end
            end
            S_MG_P:
            begin
                ps_next = frd[63:32]; pl_next = frd[31:0];
                wpos_next = '0; i_next = CW'(1); state_next = S_MG_RD;
            end
            S_MG_RD:
            begin
                if (i_reg >= count_reg) state_next = S_MG_END;
                else state_next = S_MG_CK;
            end
            S_MG_CK:
            begin
                if (ps_reg + pl_reg == frd[63:32] - HDR[31:0])
                    pl_next = pl_reg + HDR[31:0] + frd[31:0];
                else
                begin
                    fwe = 1'b1; faddr = FW'(wpos_reg); fwd = {ps_reg, pl_reg};
                    ps_next = frd[63:32]; pl_next = frd[31:0];
                    wpos_next = wpos_reg + CW'(1);
                end
                i_next = i_reg + CW'(1); state_next = S_MG_RD;
            end
            S_MG_END:
            begin
                fwe = 1'b1; faddr = FW'(wpos_reg); fwd = {ps_reg, pl_reg};
                count_next = wpos_reg + CW'(1); state_next = S_DONE;
            end
            // hold until the output register is free, then hand the result over
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next = 1'b1; out_next = res_reg; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ov_reg     <= 1'b0;
            count_reg  <= '0;
            lvalid_reg <= '0;
            ret_reg    <= S_IDLE;
        end
        else
        begin
            state_reg  <= state_next;
            ov_reg     <= ov_next;
            count_reg  <= count_next;
            lvalid_reg <= lvalid_next;
            ret_reg    <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; i_reg <= i_next; pos_reg <= pos_next; j_reg <= j_next;
        k_reg <= k_next; wpos_reg <= wpos_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
        c_v_reg <= c_v_next; size_reg <= size_next; slack_reg <= slack_next;
        ps_reg <= ps_next; pl_reg <= pl_next; slot_reg <= slot_next;
        res_reg <= res_next; out_reg <= out_next;
    end
endmodule
`default_nettype wire
